// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the OOK socket sender RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset
`define OORS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication
`define OORS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define OORS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/oors_pkg.sv =====
// Shared types, constants and the device code table for the OOK socket sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package oors_pkg;

    // Frame layout
    localparam int unsigned FRAME_BITS    = 25;
    localparam int unsigned CMD_BITS      = 17;
    localparam int unsigned BIT_POS_W     = 5;
    localparam logic [CMD_BITS-1:0] CMD_ON_BITS = 17'h00180;

    // Register reset values
    localparam logic [15:0] ZERO_HIGH_RST  = 16'd250;
    localparam logic [15:0] ZERO_LOW_RST   = 16'd650;
    localparam logic [15:0] ONE_HIGH_RST   = 16'd700;
    localparam logic [15:0] ONE_LOW_RST    = 16'd200;
    localparam logic [19:0] FRAME_GAP_RST  = 20'd7000;
    localparam logic [23:0] FINAL_HOLD_RST = 24'd1000000;
    localparam logic [7:0]  REPEAT_RST     = 8'd20;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned TICK_W     = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH  = 3'd0,
        CFG_ZERO_LOW   = 3'd1,
        CFG_ONE_HIGH   = 3'd2,
        CFG_ONE_LOW    = 3'd3,
        CFG_FRAME_GAP  = 3'd4,
        CFG_FINAL_HOLD = 3'd5,
        CFG_REPEAT     = 3'd6
    } cfg_idx_t;

    // Transmit sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HIGH = 3'd1,
        PH_LOW  = 3'd2,
        PH_GAP  = 3'd3,
        PH_HOLD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] zero_high_ticks;
        logic [15:0] zero_low_ticks;
        logic [15:0] one_high_ticks;
        logic [15:0] one_low_ticks;
        logic [19:0] frame_gap_ticks;
        logic [23:0] final_hold_ticks;
        logic [7:0]  repeat_count;
    } oors_cfg_t;

    typedef struct packed {
        logic       opcode;
        logic [2:0] device_number;
        logic       switch_on;
    } oors_item_t;

    typedef struct packed {
        logic start_accepted;
        logic busy_res;
        logic line_level;
    } oors_res_t;

    // Socket address codes; unused numbers map to zero
    function automatic logic [7:0] dev_code(input logic [2:0] dev);
        logic [7:0] code;
        case (dev)
            3'd1:    code = 8'h3F;
            3'd2:    code = 8'h0F;
            3'd3:    code = 8'h33;
            3'd4:    code = 8'h03;
            3'd5:    code = 8'h3C;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/oors_cfg.sv =====
// Configuration register file for the OOK socket sender.
// Depends on oors_pkg for register indexes, reset values and the config struct.
`default_nettype none

module oors_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [oors_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [oors_pkg::CFG_DATA_W-1:0]     cfg_data,
    output oors_pkg::oors_cfg_t                      cfg_o
);
    import oors_pkg::*;

    oors_cfg_t cfg_reg;
    oors_cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register decode; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ZERO_HIGH:  cfg_next.zero_high_ticks  = cfg_data[15:0];
                CFG_ZERO_LOW:   cfg_next.zero_low_ticks   = cfg_data[15:0];
                CFG_ONE_HIGH:   cfg_next.one_high_ticks   = cfg_data[15:0];
                CFG_ONE_LOW:    cfg_next.one_low_ticks    = cfg_data[15:0];
                CFG_FRAME_GAP:  cfg_next.frame_gap_ticks  = cfg_data[19:0];
                CFG_FINAL_HOLD: cfg_next.final_hold_ticks = cfg_data[23:0];
                CFG_REPEAT:     cfg_next.repeat_count     = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_high_ticks  <= ZERO_HIGH_RST;
            cfg_reg.zero_low_ticks   <= ZERO_LOW_RST;
            cfg_reg.one_high_ticks   <= ONE_HIGH_RST;
            cfg_reg.one_low_ticks    <= ONE_LOW_RST;
            cfg_reg.frame_gap_ticks  <= FRAME_GAP_RST;
            cfg_reg.final_hold_ticks <= FINAL_HOLD_RST;
            cfg_reg.repeat_count     <= REPEAT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/oors_seq.sv =====
// Frame sequencer: phase, bit position, repeat and tick counters, one step per word.
// Depends on oors_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module oors_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv_i,
    input  wire oors_pkg::oors_item_t item_i,
    input  wire oors_pkg::oors_cfg_t  cfg_i,
    output oors_pkg::oors_res_t       res_o
);
    import oors_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [FRAME_BITS-1:0]  frame_word_reg, frame_word_next;
    logic [BIT_POS_W-1:0]   bit_position_reg, bit_position_next;
    logic [7:0]             repeats_done_reg, repeats_done_next;
    logic [TICK_W-1:0]      tick_count_reg, tick_count_next;

    // State after a possible start
    logic                   start;
    phase_t                 ph_s;
    logic [FRAME_BITS-1:0]  fw_s;
    logic [BIT_POS_W-1:0]   bp_s;
    logic [7:0]             rd_s;
    logic [TICK_W-1:0]      tc_s;

    logic                   cur_bit;
    logic [TICK_W-1:0]      tc_inc;
    logic [15:0]            hi_raw, lo_raw;
    logic [TICK_W-1:0]      hi_lim, lo_lim;
    logic [7:0]             rep_lim, rd_sat;
    phase_t                 hold_phase;

    // Start command: only while idle and for sockets 1 to 5
    always_comb begin
        start = item_i.opcode && (phase_reg == PH_IDLE)
                && (item_i.device_number inside {[3'd1:3'd5]});
        ph_s = phase_reg;
        fw_s = frame_word_reg;
        bp_s = bit_position_reg;
        rd_s = repeats_done_reg;
        tc_s = tick_count_reg;
        if (start) begin
            ph_s = PH_HIGH;
            fw_s = {dev_code(item_i.device_number),
                    (item_i.switch_on ? CMD_ON_BITS : {CMD_BITS{1'b0}})};
            bp_s = '0;
            rd_s = '0;
            tc_s = '0;
        end
    end

    // Current bit, sent MSB first
    always_comb begin
        if (bp_s < BIT_POS_W'(FRAME_BITS)) begin
            cur_bit = fw_s[BIT_POS_W'(FRAME_BITS - 1) - bp_s];
        end else begin
            cur_bit = 1'b0;
        end
    end

    // Duration limits, a zero bit time lasts one tick
    assign hi_raw     = cur_bit ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks;
    assign lo_raw     = cur_bit ? cfg_i.one_low_ticks  : cfg_i.zero_low_ticks;
    assign hi_lim     = (hi_raw == 16'd0) ? TICK_W'(1) : TICK_W'(hi_raw);
    assign lo_lim     = (lo_raw == 16'd0) ? TICK_W'(1) : TICK_W'(lo_raw);
    assign rep_lim    = (cfg_i.repeat_count == 8'd0) ? 8'd1 : cfg_i.repeat_count;
    assign rd_sat     = (rd_s == 8'hFF) ? rd_s : rd_s + 8'd1;
    assign hold_phase = (cfg_i.final_hold_ticks == '0) ? PH_IDLE : PH_HOLD;
    assign tc_inc     = tc_s + TICK_W'(1);

    // Phase transitions
    always_comb begin
        phase_next        = ph_s;
        frame_word_next   = fw_s;
        bit_position_next = bp_s;
        repeats_done_next = rd_s;
        tick_count_next   = tc_s;
        case (ph_s)
            PH_IDLE: begin
                tick_count_next = tc_s;
            end
            PH_HIGH: begin
                if (tc_inc >= hi_lim) begin
                    tick_count_next = '0;
                    phase_next      = PH_LOW;
                end else begin
                    tick_count_next = tc_inc;
                end
            end
            PH_LOW: begin
                if (tc_inc >= lo_lim) begin
                    tick_count_next = '0;
                    if (bp_s >= BIT_POS_W'(FRAME_BITS - 1)) begin
                        // end of frame: count it, then gap, next frame or final hold
                        repeats_done_next = rd_sat;
                        if (cfg_i.frame_gap_ticks != '0) begin
                            phase_next = PH_GAP;
                        end else if (rd_sat >= rep_lim) begin
                            phase_next = hold_phase;
                        end else begin
                            bit_position_next = '0;
                            phase_next        = PH_HIGH;
                        end
                    end else begin
                        bit_position_next = bp_s + BIT_POS_W'(1);
                        phase_next        = PH_HIGH;
                    end
                end else begin
                    tick_count_next = tc_inc;
                end
            end
            PH_GAP: begin
                if (tc_inc >= TICK_W'(cfg_i.frame_gap_ticks)) begin
                    tick_count_next = '0;
                    if (rd_s >= rep_lim) begin
                        phase_next = hold_phase;
                    end else begin
                        bit_position_next = '0;
                        phase_next        = PH_HIGH;
                    end
                end else begin
                    tick_count_next = tc_inc;
                end
            end
            PH_HOLD: begin
                if (tc_inc >= cfg_i.final_hold_ticks) begin
                    tick_count_next = '0;
                    phase_next      = PH_IDLE;
                end else begin
                    tick_count_next = tc_inc;
                end
            end
            default: begin
                tick_count_next = '0;
                phase_next      = PH_IDLE;
            end
        endcase
    end

    // Result of this tick
    assign res_o.line_level     = (ph_s == PH_HIGH);
    assign res_o.busy_res       = (ph_s != PH_IDLE);
    assign res_o.start_accepted = start;

    // State registers, stepped once per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            frame_word_reg   <= '0;
            bit_position_reg <= '0;
            repeats_done_reg <= '0;
            tick_count_reg   <= '0;
        end else if (adv_i) begin
            phase_reg        <= phase_next;
            frame_word_reg   <= frame_word_next;
            bit_position_reg <= bit_position_next;
            repeats_done_reg <= repeats_done_next;
            tick_count_reg   <= tick_count_next;
        end
    end

    `OORS_ASSERT(a_bitpos_range, aclk, aresetn, bit_position_reg < BIT_POS_W'(FRAME_BITS), "bit position past frame end")
    `OORS_ASSERT_NXT(a_hold_when_stalled, aclk, aresetn, !adv_i, $stable(phase_reg) && $stable(tick_count_reg), "sequencer moved without a word")
    `OORS_ASSERT_NXT(a_idle_stays, aclk, aresetn, adv_i && (phase_reg == PH_IDLE) && !start, phase_reg == PH_IDLE, "left idle without a start")

endmodule

`default_nettype wire

// ===== rtl/core/ook_remote_socket_code_sender_unit.sv =====
// OOK remote socket code sender, top level.
// Pipeline: input register, single-pass sequencer step, result register to m_tdata.
// Throughput: one word per cycle unless m_tready stalls the result register.
// Reset (aresetn low, synchronous): sequencer idle, pipeline empty, registers at defaults.
`default_nettype none
`include "assert_macros.svh"

module ook_remote_socket_code_sender_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input word stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [2:0] device_number, [3] switch_on
    input  wire logic [0:0]                       s_tuser,  // [0] opcode
    // result word stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,  // [0] line_level, [1] busy_res,
                                                            // [2] start_accepted
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [oors_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [oors_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import oors_pkg::*;

    oors_cfg_t  cfg;
    oors_item_t in_item_reg;
    logic       in_valid_reg, in_valid_next;
    oors_res_t  seq_res;
    oors_res_t  res_reg;
    logic       out_valid_reg, out_valid_next;
    logic       adv;
    logic       in_take;

    oors_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    // Step when an input word is held and the result slot is free or draining
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign in_take  = s_tvalid && s_tready;

    oors_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv_i   (adv),
        .item_i  (in_item_reg),
        .cfg_i   (cfg),
        .res_o   (seq_res)
    );

    // Pipeline valid flags
    always_comb begin
        in_valid_next  = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
        out_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.opcode        <= s_tuser[0];
            in_item_reg.device_number <= s_tdata[2:0];
            in_item_reg.switch_on     <= s_tdata[3];
        end
        if (adv) begin
            res_reg <= seq_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg.start_accepted, res_reg.busy_res, res_reg.line_level};

    `OORS_ASSERT_IMP(a_start_busy, aclk, aresetn, out_valid_reg && res_reg.start_accepted, res_reg.busy_res, "accepted start without busy")
    `OORS_ASSERT_IMP(a_line_busy, aclk, aresetn, out_valid_reg && res_reg.line_level, res_reg.busy_res, "line high while not busy")
    `OORS_ASSERT_NXT(a_in_kept, aclk, aresetn, in_valid_reg && !adv, in_valid_reg, "held input word dropped")

endmodule

`default_nettype wire

// ===== tb/ook_socket_tx_checker.sv =====
// Scoreboard for the OOK socket sender: watches the tick, result and config channels.
// Keeps its own model of the transmit sequencer and compares every result word.
// Depends on oors_pkg for the config, item, result and phase types.
`timescale 1ns / 1ps

module ook_socket_tx_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,  // [2:0] device_number, [3] switch_on
    input  wire logic [0:0]                       s_tuser,  // [0] opcode
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [7:0]                       m_tdata,  // [0] line_level, [1] busy_res,
                                                            // [2] start_accepted
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [oors_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [oors_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                    mismatches,
    output int                                    results_owed
);
    import oors_pkg::*;

    localparam int PRINT_CAP = 100;

    // Shadow of the register file and the sequencer state
    oors_cfg_t      shadow_cfg;
    phase_t         tx_phase;
    logic [24:0]    tx_frame;
    logic [4:0]     tx_bit;
    logic [7:0]     frames_sent;
    logic [23:0]    phase_ticks;

    // Expected result words, oldest first
    oors_res_t      levels_due[$];
    int unsigned    words_seen;

    initial begin
        mismatches   = 0;
        results_owed = 0;
        words_seen   = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t: result word %0d: %s", $time, words_seen, msg);
        mismatches++;
    endtask

    // Socket address byte for each device number; unused numbers give zero
    function automatic logic [7:0] socket_addr(input logic [2:0] num);
        case (num)
            3'd1:    return 8'h3F;
            3'd2:    return 8'h0F;
            3'd3:    return 8'h33;
            3'd4:    return 8'h03;
            3'd5:    return 8'h3C;
            default: return 8'h00;
        endcase
    endfunction

    // Bit durations of zero still last one tick
    function automatic logic [15:0] nonzero_ticks(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    // End of a gap: next repetition, or the final hold (skipped when zero)
    function automatic void finish_gap();
        logic [7:0] reps_wanted;
        reps_wanted = (shadow_cfg.repeat_count == 8'd0) ? 8'd1 : shadow_cfg.repeat_count;
        phase_ticks = '0;
        if (frames_sent >= reps_wanted) begin
            tx_phase = (shadow_cfg.final_hold_ticks == 24'd0) ? PH_IDLE : PH_HOLD;
        end else begin
            tx_bit   = '0;
            tx_phase = PH_HIGH;
        end
    endfunction

    // One tick of the transmitter: returns the result word it causes
    function automatic oors_res_t tx_tick(input oors_item_t item);
        oors_res_t   res;
        logic [16:0] cmd;
        logic        cur;
        logic [15:0] dur;
        res = '0;

        // start only from idle and only for sockets 1 to 5
        if (item.opcode && tx_phase == PH_IDLE &&
            item.device_number >= 3'd1 && item.device_number <= 3'd5) begin
            cmd = item.switch_on ? CMD_ON_BITS : 17'd0;
            tx_frame    = {socket_addr(item.device_number), cmd};
            tx_bit      = '0;
            frames_sent = '0;
            phase_ticks = '0;
            tx_phase    = PH_HIGH;
            res.start_accepted = 1'b1;
        end

        res.line_level = (tx_phase == PH_HIGH);
        res.busy_res   = (tx_phase != PH_IDLE);

        if (tx_phase != PH_IDLE) begin
            phase_ticks = phase_ticks + 24'd1;
            cur = (tx_bit < FRAME_BITS) ? tx_frame[FRAME_BITS - 1 - tx_bit] : 1'b0;
            case (tx_phase)
                PH_HIGH: begin
                    dur = nonzero_ticks(cur ? shadow_cfg.one_high_ticks
                                            : shadow_cfg.zero_high_ticks);
                    if (phase_ticks >= 24'(dur)) begin
                        phase_ticks = '0;
                        tx_phase    = PH_LOW;
                    end
                end
                PH_LOW: begin
                    dur = nonzero_ticks(cur ? shadow_cfg.one_low_ticks
                                            : shadow_cfg.zero_low_ticks);
                    if (phase_ticks >= 24'(dur)) begin
                        phase_ticks = '0;
                        if (32'(tx_bit) + 1 >= FRAME_BITS) begin
                            // frame done; a nonzero gap follows every frame, the last one too
                            if (frames_sent != 8'd255) frames_sent++;
                            if (shadow_cfg.frame_gap_ticks == 20'd0) finish_gap();
                            else tx_phase = PH_GAP;
                        end else begin
                            tx_bit++;
                            tx_phase = PH_HIGH;
                        end
                    end
                end
                PH_GAP: begin
                    if (phase_ticks >= 24'(shadow_cfg.frame_gap_ticks)) finish_gap();
                end
                PH_HOLD: begin
                    if (phase_ticks >= shadow_cfg.final_hold_ticks) begin
                        phase_ticks = '0;
                        tx_phase    = PH_IDLE;
                    end
                end
                default: begin
                    phase_ticks = '0;
                    tx_phase    = PH_IDLE;
                end
            endcase
        end
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        oors_item_t item;
        oors_res_t  seen;
        oors_res_t  want;
        if (!aresetn) begin
            shadow_cfg.zero_high_ticks  = ZERO_HIGH_RST;
            shadow_cfg.zero_low_ticks   = ZERO_LOW_RST;
            shadow_cfg.one_high_ticks   = ONE_HIGH_RST;
            shadow_cfg.one_low_ticks    = ONE_LOW_RST;
            shadow_cfg.frame_gap_ticks  = FRAME_GAP_RST;
            shadow_cfg.final_hold_ticks = FINAL_HOLD_RST;
            shadow_cfg.repeat_count     = REPEAT_RST;
            tx_phase    = PH_IDLE;
            tx_frame    = '0;
            tx_bit      = '0;
            frames_sent = '0;
            phase_ticks = '0;
            levels_due.delete();
        end else begin
            // register writes; data above each register's width is dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ZERO_HIGH:  shadow_cfg.zero_high_ticks  = cfg_data[15:0];
                    CFG_ZERO_LOW:   shadow_cfg.zero_low_ticks   = cfg_data[15:0];
                    CFG_ONE_HIGH:   shadow_cfg.one_high_ticks   = cfg_data[15:0];
                    CFG_ONE_LOW:    shadow_cfg.one_low_ticks    = cfg_data[15:0];
                    CFG_FRAME_GAP:  shadow_cfg.frame_gap_ticks  = cfg_data[19:0];
                    CFG_FINAL_HOLD: shadow_cfg.final_hold_ticks = cfg_data[23:0];
                    CFG_REPEAT:     shadow_cfg.repeat_count     = cfg_data[7:0];
                    default: ;
                endcase
            end

            // result words are checked before this edge's tick is predicted
            if (m_tvalid && m_tready) begin
                seen = oors_res_t'(m_tdata[2:0]);
                if (levels_due.size() == 0) begin
                    report_mismatch($sformatf("word %03b with nothing expected", m_tdata[2:0]));
                end else begin
                    want = levels_due.pop_front();
                    if (seen.line_level !== want.line_level)
                        report_mismatch($sformatf("line_level %b, expected %b",
                                                  seen.line_level, want.line_level));
                    if (seen.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res %b, expected %b",
                                                  seen.busy_res, want.busy_res));
                    if (seen.start_accepted !== want.start_accepted)
                        report_mismatch($sformatf("start_accepted %b, expected %b",
                                                  seen.start_accepted, want.start_accepted));
                end
                words_seen++;
            end

            if (s_tvalid && s_tready) begin
                item.opcode        = s_tuser[0];
                item.device_number = s_tdata[2:0];
                item.switch_on     = s_tdata[3];
                levels_due.push_back(tx_tick(item));
            end
        end
        results_owed <= levels_due.size();
    end

endmodule

// ===== tb/ook_remote_socket_code_sender_unit_tb.sv =====
// Testbench top for the OOK socket sender: clock, reset, tick and config stimulus.
// Instantiates the block and ook_socket_tx_checker, which does all result checking.
// Depends on oors_pkg and the RTL top ook_remote_socket_code_sender_unit.
`timescale 1ns / 1ps

module ook_remote_socket_code_sender_unit_tb;
    import oors_pkg::*;

    localparam logic                 OP_TICK       = 1'b0;
    localparam logic                 OP_START      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;   // no register behind it
    localparam int                   STALL_LIMIT   = 1000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int  mismatches;
    int  results_owed;
    int  quiet_cycles = 0;
    bit  bursts_on    = 1'b1;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ook_remote_socket_code_sender_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ook_socket_tx_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // Result side: ready with random stall bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (bursts_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("ook_remote_socket_code_sender_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One tick word; valid stays high between back-to-back words
    task automatic send_tick(input logic op, input logic [2:0] dev, input logic on);
        if (bursts_on && $urandom_range(0, 11) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, on, dev};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Caller drops cfg_valid after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Full register set; unused upper data bits sometimes carry junk
    task automatic write_all(input logic [15:0] zero_hi, input logic [15:0] zero_lo,
                             input logic [15:0] one_hi, input logic [15:0] one_lo,
                             input logic [19:0] gap, input logic [23:0] hold,
                             input logic [7:0] reps);
        logic [23:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? 24'($urandom) : 24'd0;
        write_reg(CFG_ZERO_HIGH,  {junk[23:16], zero_hi});
        write_reg(CFG_ZERO_LOW,   {junk[23:16], zero_lo});
        write_reg(CFG_ONE_HIGH,   {junk[23:16], one_hi});
        write_reg(CFG_ONE_LOW,    {junk[23:16], one_lo});
        write_reg(CFG_FRAME_GAP,  {junk[23:20], gap});
        write_reg(CFG_FINAL_HOLD, hold);
        write_reg(CFG_REPEAT,     {junk[23:8], reps});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random ticks; starts mostly name a real socket
    task automatic run_ticks(input int count, input int start_pct);
        logic       op;
        logic [2:0] dev;
        logic       on;
        for (int k = 0; k < count; k++) begin
            op  = ($urandom_range(0, 99) < start_pct) ? OP_START : OP_TICK;
            dev = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 5));
            on  = 1'($urandom_range(0, 1));
            send_tick(op, dev, on);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // write to an index with no register: must change nothing
        write_reg(CFG_IDX_SPARE, 24'($urandom));
        cfg_valid <= 1'b0;

        // directed, reset timing: bad sockets, a good start, starts while busy
        send_tick(OP_TICK,  3'd0, 1'b0);
        send_tick(OP_TICK,  3'd7, 1'b1);
        send_tick(OP_START, 3'd0, 1'b1);
        send_tick(OP_START, 3'd6, 1'b0);
        send_tick(OP_START, 3'd7, 1'b1);
        send_tick(OP_START, 3'd1, 1'b1);
        send_tick(OP_START, 3'd5, 1'b0);
        send_tick(OP_START, 3'd3, 1'b1);
        send_tick(OP_START, 3'd0, 1'b0);
        send_tick(OP_TICK,  3'd2, 1'b0);
        send_tick(OP_TICK,  3'd4, 1'b1);
        send_tick(OP_TICK,  3'd6, 1'b0);
        wait_idle();

        // zero bit times, zero gap, zero hold, zero repeat count
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 20'd0, 24'd0, 8'd0);
        run_ticks(150, 8);
        wait_idle();

        // short random timings
        repeat (5) begin
            write_all(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      20'($urandom_range(0, 6)), 24'($urandom_range(0, 10)),
                      8'($urandom_range(0, 3)));
            run_ticks(120, 8);
            wait_idle();
        end

        // ones and zeros with clearly different shapes
        write_all(16'd1, 16'd3, 16'd4, 16'd1, 20'd2, 24'd3, 8'd2);
        run_ticks(100, 8);
        wait_idle();

        // every register at its largest value
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 24'hFFFFFF, 8'hFF);
        run_ticks(40, 20);
        wait_idle();

        // last stretch runs without any stall on either side
        bursts_on = 1'b0;
        write_all(16'd2, 16'd1, 16'd1, 16'd2, 20'd3, 24'd4, 8'd3);
        run_ticks(150, 8);
        wait_idle();

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("ook_remote_socket_code_sender_unit: match");
        end else begin
            $display("ook_remote_socket_code_sender_unit: mismatch");
        end
        $finish;
    end

endmodule
